/* hdl/fxpid_pkg.sv */
// Package for the fixed-point PID controller: payload and configuration types,
// register indexes, datapath widths and the integral clamp function.
// No dependencies.
`default_nettype none

package fxpid_pkg;

    localparam int FRAC_BITS = 15;

    // Widths of the datapath
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int GAIN_W  = 16;
    localparam int PROD_W  = GAIN_W + ERR_W;
    localparam int DPROD_W = GAIN_W + DIFF_W;
    localparam int ISUM_W  = 32;
    localparam int ILIM_W  = 31;
    localparam int SUM_W   = 40;
    localparam int OUT_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_UPPER_LIMIT    = 3'd3,
        REG_LOWER_LIMIT    = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5
    } t_cfg_idx;

    localparam logic signed [15:0]       RST_UPPER_LIMIT    = 16'sd1000;
    localparam logic signed [15:0]       RST_LOWER_LIMIT    = -16'sd1000;
    localparam logic [ILIM_W-1:0]        RST_INTEGRAL_LIMIT = 31'd52428800;

    typedef enum logic [1:0] {
        HIT_NONE  = 2'd0,
        HIT_UPPER = 2'd1,
        HIT_LOWER = 2'd2
    } t_limit_hit;

    typedef struct packed {
        logic signed [15:0] target_value;
        logic signed [15:0] measured_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] drive_value;
        t_limit_hit         limit_hit;
    } t_out_item;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic signed [15:0]       upper_limit;
        logic signed [15:0]       lower_limit;
        logic [ILIM_W-1:0]        integral_limit;
    } t_cfg;

    // Products handed from the multiply stage to the integrator stage
    typedef struct packed {
        logic signed [PROD_W-1:0]  inc;
        logic signed [PROD_W-1:0]  p_term;
        logic signed [DPROD_W-1:0] d_term;
        logic                      err_pos;
        logic                      err_neg;
    } t_terms;

    function automatic logic signed [SUM_W-1:0] fxpid_clamp(
        input logic signed [SUM_W-1:0] v,
        input logic [ILIM_W-1:0]       lim
    );
        logic signed [SUM_W-1:0] pos;
        logic signed [SUM_W-1:0] neg;
        pos = $signed({{(SUM_W-ILIM_W){1'b0}}, lim});
        neg = -pos;
        if (v > pos) begin
            return pos;
        end else if (v < neg) begin
            return neg;
        end else begin
            return v;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/fxpid_cfg_regs.sv */
// Configuration register file of the PID controller.
// Depends on fxpid_pkg.
`default_nettype none

module fxpid_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fxpid_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fxpid_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output fxpid_pkg::t_cfg                        o_cfg
);
    import fxpid_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain      <= '0;
            r_cfg.integ_gain     <= '0;
            r_cfg.deriv_gain     <= '0;
            r_cfg.upper_limit    <= RST_UPPER_LIMIT;
            r_cfg.lower_limit    <= RST_LOWER_LIMIT;
            r_cfg.integral_limit <= RST_INTEGRAL_LIMIT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_PROP_GAIN:      r_cfg.prop_gain      <= $signed(i_cfg_data[15:0]);
                REG_INTEG_GAIN:     r_cfg.integ_gain     <= $signed(i_cfg_data[15:0]);
                REG_DERIV_GAIN:     r_cfg.deriv_gain     <= $signed(i_cfg_data[15:0]);
                REG_UPPER_LIMIT:    r_cfg.upper_limit    <= $signed(i_cfg_data[15:0]);
                REG_LOWER_LIMIT:    r_cfg.lower_limit    <= $signed(i_cfg_data[15:0]);
                REG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_data[ILIM_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hdl/fxpid_front.sv */
// Front of the PID pipeline: input register with the error, then the
// registered gain products. Holds the previous error.
// Depends on fxpid_pkg.
`default_nettype none

module fxpid_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fxpid_pkg::t_cfg     i_cfg,
    input  wire logic                i_in_valid,
    input  wire fxpid_pkg::t_in_item i_in_data,
    output logic                     o_in_ready,
    input  wire logic                i_adv_next,
    output logic                     o_terms_valid,
    output fxpid_pkg::t_terms        o_terms
);
    import fxpid_pkg::*;

    logic                     r_s1_valid;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  r_last_err;
    logic                     r_s2_valid;
    t_terms                   r_terms;

    logic                     adv_s1;
    logic                     adv_s2;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [DIFF_W-1:0] diff;
    t_terms                   n_terms;

    // a stage moves when the next one is empty or moving too
    assign adv_s2 = !r_s2_valid || i_adv_next;
    assign adv_s1 = !r_s1_valid || adv_s2;

    assign n_err = ERR_W'(i_in_data.target_value) - ERR_W'(i_in_data.measured_value);
    assign diff  = DIFF_W'(r_err) - DIFF_W'(r_last_err);

    always_comb begin
        n_terms.inc     = PROD_W'(i_cfg.integ_gain) * PROD_W'(r_err);
        n_terms.p_term  = PROD_W'(i_cfg.prop_gain) * PROD_W'(r_err);
        n_terms.d_term  = DPROD_W'(i_cfg.deriv_gain) * DPROD_W'(diff);
        n_terms.err_pos = !r_err[ERR_W-1] && (r_err != '0);
        n_terms.err_neg = r_err[ERR_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_last_err <= '0;
        end else begin
            if (adv_s1) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv_s2) begin
                r_s2_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_last_err <= r_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s1 && i_in_valid) begin
            r_err <= n_err;
        end
        if (adv_s2 && r_s1_valid) begin
            r_terms <= n_terms;
        end
    end

    assign o_in_ready    = adv_s1;
    assign o_terms_valid = r_s2_valid;
    assign o_terms       = r_terms;

endmodule

`default_nettype wire

/* hdl/fxpid_loop.sv */
// Integrator stage of the PID controller: integral update and clamp, output
// sum, limit check with anti-windup take-back, and the result register.
// Depends on fxpid_pkg.
`default_nettype none

module fxpid_loop (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire fxpid_pkg::t_cfg i_cfg,
    input  wire logic            i_terms_valid,
    input  wire fxpid_pkg::t_terms i_terms,
    output logic                 o_adv,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output fxpid_pkg::t_out_item o_out_data
);
    import fxpid_pkg::*;

    logic signed [ISUM_W-1:0] r_isum;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     adv;
    logic signed [SUM_W-1:0]  inc;
    logic signed [SUM_W-1:0]  isum_add;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  hi;
    logic signed [SUM_W-1:0]  lo;
    logic signed [SUM_W-1:0]  result;
    logic signed [SUM_W-1:0]  isum_fin;
    logic signed [SUM_W-1:0]  scaled;
    t_out_item                n_out;
    logic signed [ISUM_W-1:0] n_isum;

    assign adv = !r_out_valid || i_out_ready;

    assign inc      = SUM_W'(i_terms.inc);
    assign isum_add = fxpid_clamp(SUM_W'(r_isum) + inc, i_cfg.integral_limit);
    assign sum      = SUM_W'(i_terms.p_term) + isum_add + SUM_W'(i_terms.d_term);
    assign hi       = SUM_W'(i_cfg.upper_limit) <<< FRAC_BITS;
    assign lo       = SUM_W'(i_cfg.lower_limit) <<< FRAC_BITS;

    always_comb begin
        result          = sum;
        isum_fin        = isum_add;
        n_out.limit_hit = HIT_NONE;
        if (sum > hi) begin
            result          = hi;
            n_out.limit_hit = HIT_UPPER;
            // take back this step's increment when pushing further up
            if (i_terms.err_pos) begin
                isum_fin = fxpid_clamp(isum_add - inc, i_cfg.integral_limit);
            end
        end else if (sum < lo) begin
            result          = lo;
            n_out.limit_hit = HIT_LOWER;
            if (i_terms.err_neg) begin
                isum_fin = fxpid_clamp(isum_add - inc, i_cfg.integral_limit);
            end
        end
        scaled            = result >>> FRAC_BITS;
        n_out.drive_value = scaled[OUT_W-1:0];
        n_isum            = isum_fin[ISUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_isum      <= '0;
        end else if (adv) begin
            r_out_valid <= i_terms_valid;
            if (i_terms_valid) begin
                r_isum <= n_isum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_terms_valid) begin
            r_out <= n_out;
        end
    end

    assign o_adv       = adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* hdl/fixed_point_pid_antiwindup.sv */
// Top level of the fixed-point PID controller with integral clamp and
// anti-windup. Depends on fxpid_pkg, fxpid_cfg_regs, fxpid_front, fxpid_loop.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   input    | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//   output   | o_out_valid / i_out_ready | o_out_data (t_out_item)
//   config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output is accepted; the result passes
// through the error register, product register and result register.
// The integral accumulator closes its loop in the result stage, once per item.
// Synchronous active-low reset clears pipeline valids, the integral, the
// previous error and the registers to their defaults. A stalled output holds;
// empty stages upstream keep filling until the pipeline is full.
`default_nettype none

module fixed_point_pid_antiwindup (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fxpid_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fxpid_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire fxpid_pkg::t_in_item               i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output fxpid_pkg::t_out_item                   o_out_data
);
    import fxpid_pkg::*;

    t_cfg   cfg;
    t_terms terms;
    logic   terms_valid;
    logic   adv_loop;

    fxpid_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fxpid_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .o_in_ready    (o_in_ready),
        .i_adv_next    (adv_loop),
        .o_terms_valid (terms_valid),
        .o_terms       (terms)
    );

    fxpid_loop u_loop (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_terms_valid (terms_valid),
        .i_terms       (terms),
        .o_adv         (adv_loop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule

`default_nettype wire
